// File: rtl/ss_pkg.sv
// Shared types and constants for the substring search block.
`default_nettype none

package ss_pkg;

    // Needle and window geometry
    localparam int NEEDLE_MAX = 16;
    localparam int HIST_DEPTH = NEEDLE_MAX - 1;
    localparam int IDX_W      = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;

    // Position counter and field widths
    localparam int POS_BITS  = 16;
    localparam int LEN_W     = 5;
    localparam int BYTE_W    = 8;
    localparam int MPOS_W    = 16;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEEDLE_LEN  = 2'd2;

    // Per-item status codes
    typedef enum logic [1:0] {
        ST_SEARCHING = 2'd0,
        ST_FOUND     = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    // Control broadcast to every history cell
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

    // One result item
    typedef struct packed {
        logic              eos;
        logic [MPOS_W-1:0] match_pos;
        status_t           status;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/ss_cell.sv
// One history cell: holds a past byte, compares it with its needle byte, passes it on.
`default_nettype none

module ss_cell (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire ss_pkg::cell_ctl_t         ctl,
    input  wire logic [ss_pkg::BYTE_W-1:0] byte_in,
    input  wire logic [ss_pkg::BYTE_W-1:0] needle_byte,
    input  wire logic                      active,
    output logic      [ss_pkg::BYTE_W-1:0] byte_out,
    output logic                           match_ok
);

    logic [ss_pkg::BYTE_W-1:0] hist_reg;
    logic [ss_pkg::BYTE_W-1:0] hist_next;

    // Clear on terminator, shift on a data byte, else hold
    always_comb begin
        hist_next = hist_reg;
        if (ctl.clear) begin
            hist_next = '0;
        end else if (ctl.shift) begin
            hist_next = byte_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg <= '0;
        end else begin
            hist_reg <= hist_next;
        end
    end

    // Positions beyond the needle always agree
    assign match_ok = !active || (hist_reg == needle_byte);
    assign byte_out = hist_reg;

endmodule

`default_nettype wire

// File: rtl/ss_skid.sv
// Two-entry output stage: result register plus skid register.
`default_nettype none

module ss_skid (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire ss_pkg::result_t in_data,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output ss_pkg::result_t      out_data
);

    logic            out_valid_reg;
    logic            out_valid_next;
    ss_pkg::result_t out_data_reg;
    ss_pkg::result_t out_data_next;
    logic            skid_valid_reg;
    logic            skid_valid_next;
    ss_pkg::result_t skid_data_reg;
    ss_pkg::result_t skid_data_next;
    logic            in_acc;

    assign in_ready = !skid_valid_reg;
    assign in_acc   = in_valid && in_ready;

    // Refill the output from the skid first, park a new item when stalled
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = in_acc;
                out_data_next  = in_data;
            end
        end else if (in_acc) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// File: rtl/substring_search.sv
// Streaming first-occurrence substring search over a chain of history cells.
// Each result is registered in the output stage before it appears on the master side.
// Throughput: one byte per cycle while s_tready is high; the whole window is compared in parallel.
// The output stage holds two results, so input stalls only when both are waiting.
// Reset (synchronous, active low) zeroes needle registers, history, counter and match latch.
// A zero byte ends the string and clears the history, counter and match latch.
`default_nettype none

module substring_search (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // configuration write port
    input  wire logic                         cfg_wr_en,
    input  wire logic [ss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ss_pkg::CFG_W-1:0]     cfg_wr_data,
    // input stream
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,   // [7:0] hay_byte
    // result stream
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [23:0]                  m_tdata,   // [1:0] status, [17:2] match_pos, pad
    output logic                              m_tlast    // end_of_string
);

    localparam int NM = ss_pkg::NEEDLE_MAX;
    localparam int BW = ss_pkg::BYTE_W;
    localparam int LW = ss_pkg::LEN_W;
    localparam int PB = ss_pkg::POS_BITS;

    // Configuration registers
    logic [ss_pkg::CFG_W-1:0] needle_low_reg;
    logic [ss_pkg::CFG_W-1:0] needle_high_reg;
    logic [LW-1:0]            needle_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            needle_low_reg  <= '0;
            needle_high_reg <= '0;
            needle_len_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                ss_pkg::CFG_NEEDLE_LOW:  needle_low_reg  <= cfg_wr_data;
                ss_pkg::CFG_NEEDLE_HIGH: needle_high_reg <= cfg_wr_data;
                ss_pkg::CFG_NEEDLE_LEN:  needle_len_reg  <= cfg_wr_data[LW-1:0];
                default: ;
            endcase
        end
    end

    // Split the needle into bytes
    logic [2*ss_pkg::CFG_W-1:0] needle_bits;
    logic [BW-1:0]              needle_b [NM];

    assign needle_bits = {needle_high_reg, needle_low_reg};

    always_comb begin
        for (int i = 0; i < NM; i++) begin
            needle_b[i] = needle_bits[BW*i +: BW];
        end
    end

    // Effective length: clamp to the maximum, stop at the first zero byte
    logic [LW-1:0] clamp_len;
    logic [LW-1:0] eff_len;

    assign clamp_len = (needle_len_reg > LW'(NM)) ? LW'(NM) : needle_len_reg;

    always_comb begin
        eff_len = clamp_len;
        for (int i = NM - 1; i >= 0; i--) begin
            if ((LW'(i) < clamp_len) && (needle_b[i] == '0)) begin
                eff_len = LW'(i);
            end
        end
    end

    // Align the needle so its last byte faces the newest window byte
    logic [BW-1:0] face_b   [NM];
    logic          face_act [NM];
    logic [LW-1:0] face_idx [NM];

    always_comb begin
        for (int k = 0; k < NM; k++) begin
            face_act[k] = LW'(k) < eff_len;
            face_idx[k] = eff_len - LW'(k + 1);
            face_b[k]   = needle_b[face_idx[k][ss_pkg::IDX_W-1:0]];
        end
    end

    // Per-string state
    logic [PB-1:0] byte_count_reg;
    logic [PB-1:0] byte_count_next;
    logic          found_reg;
    logic          found_next;
    logic [PB-1:0] start_reg;
    logic [PB-1:0] start_next;

    logic          in_acc;
    logic [BW-1:0] hay_b;
    logic          is_term;
    logic          in_ready;

    assign hay_b   = s_tdata;
    assign is_term = (hay_b == '0);
    assign in_acc  = s_tvalid && in_ready;

    // Byte chain through the history cells; entry 0 is the incoming byte
    ss_pkg::cell_ctl_t cell_ctl;
    logic [BW-1:0]     chain [NM];
    logic [NM-1:0]     ok_vec;

    assign cell_ctl.shift = in_acc && !is_term;
    assign cell_ctl.clear = in_acc && is_term;
    assign chain[0]       = hay_b;
    assign ok_vec[0]      = !face_act[0] || (hay_b == face_b[0]);

    for (genvar j = 0; j < ss_pkg::HIST_DEPTH; j++) begin : g_cell
        ss_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (cell_ctl),
            .byte_in     (chain[j]),
            .needle_byte (face_b[j+1]),
            .active      (face_act[j+1]),
            .byte_out    (chain[j+1]),
            .match_ok    (ok_vec[j+1])
        );
    end

    // Match decision for this byte
    logic          window_full;
    logic [PB:0]   count_plus;
    logic [PB-1:0] start_cand;

    assign count_plus  = {1'b0, byte_count_reg} + (PB+1)'(1);
    assign window_full = count_plus >= (PB+1)'(eff_len);
    assign start_cand  = byte_count_reg - PB'(eff_len - LW'(1));

    always_comb begin
        found_next = found_reg;
        start_next = start_reg;
        if (!found_reg) begin
            if (eff_len == '0) begin
                found_next = 1'b1;
                start_next = '0;
            end else if (!is_term && window_full && (&ok_vec)) begin
                found_next = 1'b1;
                start_next = start_cand;
            end
        end
    end

    // Saturating position counter
    always_comb begin
        byte_count_next = byte_count_reg;
        if (byte_count_reg != '1) begin
            byte_count_next = byte_count_reg + PB'(1);
        end
    end

    // Advance state on each taken item, clear on the terminator
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            found_reg      <= 1'b0;
            start_reg      <= '0;
        end else if (in_acc) begin
            if (is_term) begin
                byte_count_reg <= '0;
                found_reg      <= 1'b0;
                start_reg      <= '0;
            end else begin
                byte_count_reg <= byte_count_next;
                found_reg      <= found_next;
                start_reg      <= start_next;
            end
        end
    end

    // Form the result item
    ss_pkg::result_t          res;
    ss_pkg::result_t          out_res;
    logic [PB+ss_pkg::MPOS_W-1:0] start_ext;

    assign start_ext = {{ss_pkg::MPOS_W{1'b0}}, start_next};

    always_comb begin
        res.eos = is_term;
        if (found_next) begin
            res.status    = ss_pkg::ST_FOUND;
            res.match_pos = start_ext[ss_pkg::MPOS_W-1:0];
        end else begin
            res.status    = is_term ? ss_pkg::ST_NOT_FOUND : ss_pkg::ST_SEARCHING;
            res.match_pos = '0;
        end
    end

    ss_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (in_ready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign s_tready = in_ready;
    assign m_tdata  = {6'b0, out_res.match_pos, out_res.status};
    assign m_tlast  = out_res.eos;

endmodule

`default_nettype wire
